### sv/sspdt_pkg.sv
package sspdt_pkg;

  // item field widths
  localparam int KIND_W  = 2;
  localparam int POS_X_W = 9;
  localparam int POS_Y_W = 8;
  localparam int VALUE_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 12;
  localparam int STEP_W     = 16;
  localparam int DEPTH_W    = 32;

  // signed span for edge compares: screen position vs edge plus size
  localparam int SPAN_W = COORD_W + 2;

  // texel coordinate arithmetic, UQ8.8 step
  localparam int FRAC_W = 8;
  localparam int PROD_W = COORD_W + STEP_W;
  localparam int TCRD_W = PROD_W - FRAC_W;

  // alpha key
  localparam int ALPHA_LSB   = 24;
  localparam int ALPHA_W     = VALUE_W - ALPHA_LSB;
  localparam int ALPHA_LIMIT = 30;

  // queue between front and back
  localparam int QDEPTH  = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_CNT_W = 4;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXEL = 2'd0,
    KIND_DEPTH = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_LEFT   = 3'd0,
    CFG_SPRITE_TOP    = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_STEP_X        = 3'd4,
    CFG_STEP_Y        = 3'd5,
    CFG_SPRITE_DEPTH  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] sprite_left;
    logic signed [COORD_W-1:0] sprite_top;
    logic [COORD_W-1:0]        sprite_width;
    logic [COORD_W-1:0]        sprite_height;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [DEPTH_W-1:0]        sprite_depth;
  } cfg_t;

endpackage

### sv/sspdt_if.sv
interface sspdt_in_if;
  logic                              valid;
  logic                              ready;
  logic [sspdt_pkg::KIND_W-1:0]      kind;
  logic [sspdt_pkg::POS_X_W-1:0]     pos_x;
  logic [sspdt_pkg::POS_Y_W-1:0]     pos_y;
  logic [sspdt_pkg::VALUE_W-1:0]     value;

  modport source (output valid, kind, pos_x, pos_y, value, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, value, output ready);
endinterface

interface sspdt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              written;
  logic [sspdt_pkg::POS_X_W-1:0]     out_x;
  logic [sspdt_pkg::POS_Y_W-1:0]     out_y;
  logic [sspdt_pkg::VALUE_W-1:0]     color;

  modport source (output valid, written, out_x, out_y, color, input ready);
  modport sink   (input valid, written, out_x, out_y, color, output ready);
endinterface

interface sspdt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sspdt_pkg::CFG_IDX_W-1:0]   addr;
  logic [sspdt_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

### sv/sspdt_regs.sv
module sspdt_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  sspdt_cfg_if.sink         cfg_i,
  output sspdt_pkg::cfg_t   cfg_o
);

  sspdt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.addr)
        sspdt_pkg::CFG_SPRITE_LEFT: begin
          cfg_d.sprite_left = cfg_i.wdata[sspdt_pkg::COORD_W-1:0];
        end
        sspdt_pkg::CFG_SPRITE_TOP: begin
          cfg_d.sprite_top = cfg_i.wdata[sspdt_pkg::COORD_W-1:0];
        end
        sspdt_pkg::CFG_SPRITE_WIDTH: begin
          cfg_d.sprite_width = cfg_i.wdata[sspdt_pkg::COORD_W-1:0];
        end
        sspdt_pkg::CFG_SPRITE_HEIGHT: begin
          cfg_d.sprite_height = cfg_i.wdata[sspdt_pkg::COORD_W-1:0];
        end
        sspdt_pkg::CFG_STEP_X: begin
          cfg_d.step_x = cfg_i.wdata[sspdt_pkg::STEP_W-1:0];
        end
        sspdt_pkg::CFG_STEP_Y: begin
          cfg_d.step_y = cfg_i.wdata[sspdt_pkg::STEP_W-1:0];
        end
        sspdt_pkg::CFG_SPRITE_DEPTH: begin
          cfg_d.sprite_depth = cfg_i.wdata[sspdt_pkg::DEPTH_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_left   <= '0;
      cfg_q.sprite_top    <= '0;
      cfg_q.sprite_width  <= '0;
      cfg_q.sprite_height <= '0;
      cfg_q.step_x        <= sspdt_pkg::STEP_RESET;
      cfg_q.step_y        <= sspdt_pkg::STEP_RESET;
      cfg_q.sprite_depth  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/sspdt_front.sv
module sspdt_front #(
  parameter int  SCREEN_W = 512,
  parameter int  SCREEN_H = 256,
  parameter int  TEX_W    = 64,
  parameter int  TEX_H    = 64,
  parameter type entry_t  = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sspdt_in_if.sink         in_i,
  input  sspdt_pkg::cfg_t  cfg_i,
  input  logic             pop_i,
  output logic             push_o,
  output entry_t           push_data_o
);

  localparam int DA_W = (SCREEN_W * SCREEN_H > 1) ? $clog2(SCREEN_W * SCREEN_H) : 1;
  localparam int TA_W = (TEX_W * TEX_H > 1) ? $clog2(TEX_W * TEX_H) : 1;
  localparam int TX_W = (TEX_W > 1) ? $clog2(TEX_W) : 1;
  localparam int TY_W = (TEX_H > 1) ? $clog2(TEX_H) : 1;
  localparam int CW   = sspdt_pkg::COORD_W;
  localparam int SW   = sspdt_pkg::SPAN_W;
  localparam int PW   = sspdt_pkg::PROD_W;
  localparam int TW   = sspdt_pkg::TCRD_W;

  // items accepted and not yet popped by the back end
  logic [sspdt_pkg::Q_CNT_W-1:0] occ_q, occ_d;
  logic                          accept;

  logic                 s1_valid_q, s2_valid_q;
  entry_t               s1_q, s1_d, s2_q;
  logic [CW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic [PW-1:0]        prod_x_q, prod_y_q;

  logic signed [SW-1:0] sx, sy, left_s, top_s, right_s, bottom_s, dx_s, dy_s;
  logic                 on_screen, on_tex, in_sprite;

  logic [TW-1:0]        tcx, tcy;
  logic [TX_W-1:0]      tx;
  logic [TY_W-1:0]      ty;

  assign in_i.ready = (occ_q < sspdt_pkg::Q_CNT_W'(sspdt_pkg::QDEPTH));
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop_i) begin
      occ_d = occ_q + 1'b1;
    end else if (!accept && pop_i) begin
      occ_d = occ_q - 1'b1;
    end
  end

  // stage 1: clip, depth test setup, store addresses
  always_comb begin
    sx       = SW'({1'b0, in_i.pos_x});
    sy       = SW'({1'b0, in_i.pos_y});
    left_s   = SW'(cfg_i.sprite_left);
    top_s    = SW'(cfg_i.sprite_top);
    right_s  = left_s + SW'({1'b0, cfg_i.sprite_width});
    bottom_s = top_s + SW'({1'b0, cfg_i.sprite_height});
    dx_s     = sx - left_s;
    dy_s     = sy - top_s;

    on_screen = (CW'(in_i.pos_x) < CW'(SCREEN_W)) && (CW'(in_i.pos_y) < CW'(SCREEN_H));
    on_tex    = (CW'(in_i.pos_x) < CW'(TEX_W)) && (CW'(in_i.pos_y) < CW'(TEX_H));
    in_sprite = (sx >= left_s) && (sx < right_s) && (sy >= top_s) && (sy < bottom_s);

    s1_d.pos_x   = in_i.pos_x;
    s1_d.pos_y   = in_i.pos_y;
    s1_d.value   = in_i.value;
    s1_d.draw    = (in_i.kind == sspdt_pkg::KIND_DRAW) && on_screen && in_sprite;
    s1_d.tex_we  = (in_i.kind == sspdt_pkg::KIND_TEXEL) && on_tex;
    s1_d.dep_set = (in_i.kind == sspdt_pkg::KIND_DEPTH) && on_screen;
    s1_d.daddr   = DA_W'(in_i.pos_y) * DA_W'(SCREEN_W) + DA_W'(in_i.pos_x);
    s1_d.taddr   = TA_W'(in_i.pos_y) * TA_W'(TEX_W) + TA_W'(in_i.pos_x);

    // offsets are in range whenever the pixel is inside the sprite
    dx_d = dx_s[CW-1:0];
    dy_d = dy_s[CW-1:0];
  end

  // stage 2 output: saturate texel coordinates and form texel address
  always_comb begin
    tcx = prod_x_q[PW-1:sspdt_pkg::FRAC_W];
    tcy = prod_y_q[PW-1:sspdt_pkg::FRAC_W];
    tx  = (tcx >= TW'(TEX_W)) ? TX_W'(TEX_W - 1) : tcx[TX_W-1:0];
    ty  = (tcy >= TW'(TEX_H)) ? TY_W'(TEX_H - 1) : tcy[TY_W-1:0];

    push_data_o = s2_q;
    if (s2_q.draw) begin
      push_data_o.taddr = TA_W'(ty) * TA_W'(TEX_W) + TA_W'(tx);
    end
  end

  assign push_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      occ_q      <= occ_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    s2_q     <= s1_q;
    prod_x_q <= PW'(dx_q) * PW'(cfg_i.step_x);
    prod_y_q <= PW'(dy_q) * PW'(cfg_i.step_y);
  end

endmodule

### sv/sspdt_fifo.sv
module sspdt_fifo #(
  parameter type entry_t = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t                         slots_q [sspdt_pkg::QDEPTH];
  logic [sspdt_pkg::Q_PTR_W-1:0]  wptr_q, rptr_q;
  logic [sspdt_pkg::Q_CNT_W-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### sv/sspdt_back.sv
module sspdt_back #(
  parameter int  SCREEN_W = 512,
  parameter int  SCREEN_H = 256,
  parameter int  TEX_W    = 64,
  parameter int  TEX_H    = 64,
  parameter type entry_t  = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sspdt_pkg::cfg_t  cfg_i,
  input  logic             empty_i,
  input  entry_t           head_i,
  output logic             pop_o,
  sspdt_out_if.source      out_o
);

  localparam int DN   = SCREEN_W * SCREEN_H;
  localparam int TN   = TEX_W * TEX_H;
  localparam int VW   = sspdt_pkg::VALUE_W;

  logic [VW-1:0] dmem [DN];
  logic [VW-1:0] tmem [TN];

  logic          s1_valid_q;
  entry_t        s1_q;
  logic [VW-1:0] drd_q, trd_q;

  // same-edge write bypass: a read issued while the prior item writes
  logic          dfwd_hit_q, dfwd_hit_d, tfwd_hit_q, tfwd_hit_d;
  logic [VW-1:0] dfwd_q, tfwd_q;

  logic          out_valid_q;
  logic          written_q;
  logic [sspdt_pkg::POS_X_W-1:0] x_q;
  logic [sspdt_pkg::POS_Y_W-1:0] y_q;
  logic [VW-1:0] color_q;

  logic          out_free, fire;
  logic [VW-1:0] stored_depth, texel, dep_wdata;
  logic          written, dep_we, tex_we;

  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = s1_valid_q && out_free;
  assign pop_o    = !empty_i && (!s1_valid_q || fire);

  always_comb begin
    stored_depth = dfwd_hit_q ? dfwd_q : drd_q;
    texel        = tfwd_hit_q ? tfwd_q : trd_q;
    written      = s1_q.draw && (cfg_i.sprite_depth < stored_depth) &&
                   (texel[VW-1:sspdt_pkg::ALPHA_LSB] <
                    sspdt_pkg::ALPHA_W'(sspdt_pkg::ALPHA_LIMIT));
    dep_we       = fire && (s1_q.dep_set || written);
    dep_wdata    = s1_q.dep_set ? s1_q.value : cfg_i.sprite_depth;
    tex_we       = fire && s1_q.tex_we;
    dfwd_hit_d   = dep_we && (s1_q.daddr == head_i.daddr);
    tfwd_hit_d   = tex_we && (s1_q.taddr == head_i.taddr);
  end

  // depth and texel stores
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dmem[s1_q.daddr] <= dep_wdata;
    end
    if (pop_o) begin
      drd_q <= dmem[head_i.daddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tex_we) begin
      tmem[s1_q.taddr] <= s1_q.value;
    end
    if (pop_o) begin
      trd_q <= tmem[head_i.taddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q       <= head_i;
      dfwd_hit_q <= dfwd_hit_d;
      dfwd_q     <= dep_wdata;
      tfwd_hit_q <= tfwd_hit_d;
      tfwd_q     <= s1_q.value;
    end
    if (fire) begin
      written_q <= written;
      x_q       <= s1_q.pos_x;
      y_q       <= s1_q.pos_y;
      color_q   <= written ? texel : '0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.written = written_q;
  assign out_o.out_x   = x_q;
  assign out_o.out_y   = y_q;
  assign out_o.color   = color_q;

endmodule

### sv/scaled_sprite_pixel_depth_test.sv
// scaled sprite pixel draw with depth test and alpha key
//
// in_i: one item per handshake. kind selects a texel load, a depth preset or
// a draw of one screen pixel. every item gives exactly one result on out_o,
// in order: written is set and color carries the texel when the pixel is drawn
// cfg_i: register writes (left, top, width, height, step x/y, sprite depth),
// always ready; the user must see writes taken only while no item is in
// flight, which the block does not enforce
// throughput: one item per cycle, sustained, with out_o.ready held high
// path to out_o.valid: two front stages, the first loaded at the accepting
// edge, then the queue, the store read stage and the result register
// the 8-entry queue and the output register decouple the sides: in_i.ready
// drops only when 8 items are accepted and not yet taken by the back end, so a
// stalled receiver backs up into the queue and never loses or repeats an item
// reset clears the control state and sets step x/y to 1.0; the texel and
// depth stores come up undefined and are not cleared by reset
module scaled_sprite_pixel_depth_test #(
  parameter int SCREEN_W = 512,
  parameter int SCREEN_H = 256,
  parameter int TEX_W    = 64,
  parameter int TEX_H    = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sspdt_in_if.sink     in_i,
  sspdt_out_if.source  out_o,
  sspdt_cfg_if.sink    cfg_i
);

  localparam int DA_W = (SCREEN_W * SCREEN_H > 1) ? $clog2(SCREEN_W * SCREEN_H) : 1;
  localparam int TA_W = (TEX_W * TEX_H > 1) ? $clog2(TEX_W * TEX_H) : 1;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic [sspdt_pkg::POS_X_W-1:0] pos_x;
    logic [sspdt_pkg::POS_Y_W-1:0] pos_y;
    logic [sspdt_pkg::VALUE_W-1:0] value;
    logic                          draw;     // on screen and inside the sprite
    logic                          tex_we;   // texel load in range
    logic                          dep_set;  // depth preset in range
    logic [DA_W-1:0]               daddr;
    logic [TA_W-1:0]               taddr;
  } entry_t;

  sspdt_pkg::cfg_t cfg;

  logic   push, pop, empty;
  entry_t push_data, head;

  sspdt_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // front: clipping, address forming, texel coordinate scaling
  sspdt_front #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .TEX_W    (TEX_W),
    .TEX_H    (TEX_H),
    .entry_t  (entry_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .pop_i       (pop),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sspdt_fifo #(
    .entry_t (entry_t)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // back: store reads, depth test, alpha key, store writes with bypass
  sspdt_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .TEX_W    (TEX_W),
    .TEX_H    (TEX_H),
    .entry_t  (entry_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### sv/sspdt_checker.sv
module sspdt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              written_i,
  input logic [sspdt_pkg::VALUE_W-1:0]     color_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(written_i) && $stable(color_i))
    else $error("stalled result changed");

  // a pixel not drawn carries no color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !written_i |-> color_i == '0)
    else $error("color without write");

  // a drawn texel passed the alpha key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && written_i |->
      color_i[sspdt_pkg::VALUE_W-1:sspdt_pkg::ALPHA_LSB] <
      sspdt_pkg::ALPHA_W'(sspdt_pkg::ALPHA_LIMIT))
    else $error("keyed texel drawn");

  // nothing leaves right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result out of reset");

endmodule

bind scaled_sprite_pixel_depth_test sspdt_checker u_sspdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .written_i   (out_o.written),
  .color_i     (out_o.color)
);

### verif/scaled_sprite_pixel_depth_test_tb.sv
module scaled_sprite_pixel_depth_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sspdt_pkg::*;

  localparam int SCREEN_W = 512;
  localparam int SCREEN_H = 256;
  localparam int TEX_W    = 64;
  localparam int TEX_H    = 64;

  // kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // cycles to let pass once the last result is in
  localparam int DRAIN_CYCLES = 12;
  // cycles with no handshake anywhere before the run is declared hung
  localparam int STUCK_LIMIT  = 5000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 160;

  typedef struct {
    logic                written;
    logic [POS_X_W-1:0]  x;
    logic [POS_Y_W-1:0]  y;
    logic [VALUE_W-1:0]  color;
  } pixel_result_t;

  logic clk_i;
  logic rst_ni;

  sspdt_in_if  in_if ();
  sspdt_out_if out_if ();
  sspdt_cfg_if cfg_if ();

  scaled_sprite_pixel_depth_test #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .TEX_W    (TEX_W),
    .TEX_H    (TEX_H)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the block: sprite registers
  int                  spr_left;
  int                  spr_top;
  int                  spr_width;
  int                  spr_height;
  logic [STEP_W-1:0]   spr_step_x;
  logic [STEP_W-1:0]   spr_step_y;
  logic [DEPTH_W-1:0]  spr_depth;

  // shadow stores, plus a mark per entry once it holds a defined value
  logic [VALUE_W-1:0]  texel_mem [TEX_W*TEX_H];
  bit                  texel_ok  [TEX_W*TEX_H];
  logic [DEPTH_W-1:0]  depth_mem [SCREEN_W*SCREEN_H];
  bit                  depth_ok  [SCREEN_W*SCREEN_H];

  pixel_result_t pending_pixels [$];

  int mismatches;
  int items_sent;
  int stuck_cycles;
  // sender pacing: stretches of back-to-back items between gappy stretches
  bit send_steady;
  int send_mode_left;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic bit covers(int sx, int sy);
    return sx >= spr_left && sx < spr_left + spr_width &&
           sy >= spr_top  && sy < spr_top + spr_height;
  endfunction

  // scaled texel coordinate, truncated, clamped to the last column or row
  function automatic int tex_coord(int delta, logic [STEP_W-1:0] step, int limit);
    longint t;
    t = (longint'(delta) * longint'(step)) >> FRAC_W;
    if (t >= limit) t = limit - 1;
    return int'(t);
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] word);
    logic signed [COORD_W-1:0] edge12;
    edge12 = word[COORD_W-1:0];
    case (idx)
      CFG_SPRITE_LEFT:   spr_left   = int'(edge12);
      CFG_SPRITE_TOP:    spr_top    = int'(edge12);
      CFG_SPRITE_WIDTH:  spr_width  = int'(word[COORD_W-1:0]);
      CFG_SPRITE_HEIGHT: spr_height = int'(word[COORD_W-1:0]);
      CFG_STEP_X:        spr_step_x = word[STEP_W-1:0];
      CFG_STEP_Y:        spr_step_y = word[STEP_W-1:0];
      CFG_SPRITE_DEPTH:  spr_depth  = word[DEPTH_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted item: update the shadow state, return the pixel it yields
  function automatic pixel_result_t predict_pixel(logic [KIND_W-1:0] kind,
                                                  logic [POS_X_W-1:0] px,
                                                  logic [POS_Y_W-1:0] py,
                                                  logic [VALUE_W-1:0] val);
    pixel_result_t res;
    int daddr;
    int tx;
    int ty;
    logic [VALUE_W-1:0] texel;
    res.written = 1'b0;
    res.x       = px;
    res.y       = py;
    res.color   = '0;
    case (kind)
      KIND_TEXEL: begin
        if (px < TEX_W && py < TEX_H) begin
          texel_mem[py*TEX_W + px] = val;
          texel_ok[py*TEX_W + px]  = 1'b1;
        end
      end
      KIND_DEPTH: begin
        if (px < SCREEN_W && py < SCREEN_H) begin
          depth_mem[py*SCREEN_W + px] = val;
          depth_ok[py*SCREEN_W + px]  = 1'b1;
        end
      end
      KIND_DRAW: begin
        if (px < SCREEN_W && py < SCREEN_H && covers(int'(px), int'(py))) begin
          daddr = py*SCREEN_W + px;
          if (spr_depth < depth_mem[daddr]) begin
            tx    = tex_coord(int'(px) - spr_left, spr_step_x, TEX_W);
            ty    = tex_coord(int'(py) - spr_top, spr_step_y, TEX_H);
            texel = texel_mem[ty*TEX_W + tx];
            if (texel[VALUE_W-1:ALPHA_LSB] < ALPHA_LIMIT) begin
              res.written      = 1'b1;
              res.color        = texel;
              depth_mem[daddr] = spr_depth;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random pick helpers
  // ---------------------------------------------------------------------------

  // idle cycles after an item: mostly none, some short, a few long
  function automatic int next_gap();
    int r;
    if (send_mode_left == 0) begin
      send_steady    = ($urandom_range(3) == 0);
      send_mode_left = $urandom_range(120, 10);
    end
    send_mode_left--;
    if (send_steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(4, 2);
    return $urandom_range(40, 8);
  endfunction

  // depth entries near the sprite depth so equal and just-farther both occur
  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(2))
      0:       return spr_depth;
      1:       return spr_depth + DEPTH_W'($urandom_range(3, 1));
      default: return $urandom();
    endcase
  endfunction

  // texels with alpha around the key limit
  function automatic logic [VALUE_W-1:0] pick_texel();
    logic [ALPHA_W-1:0] alpha;
    logic [VALUE_W-1:0] rgb;
    rgb = $urandom();
    case ($urandom_range(3))
      0:       alpha = ALPHA_W'(ALPHA_LIMIT - 1);
      1:       alpha = ALPHA_W'(ALPHA_LIMIT);
      2:       alpha = ALPHA_W'($urandom_range(ALPHA_LIMIT - 1));
      default: alpha = ALPHA_W'($urandom());
    endcase
    return {alpha, rgb[ALPHA_LSB-1:0]};
  endfunction

  function automatic int pick_edge(int span);
    case ($urandom_range(19))
      0:       return -2048;
      1:       return 2047;
      default: return int'($urandom_range(span + 40)) - 80;
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 4095;
      2, 3:    return $urandom_range(300, 1);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(7))
      0, 1:    return STEP_RESET;
      2:       return '0;
      3:       return '1;
      4, 5:    return STEP_W'($urandom_range(600));
      default: return STEP_W'($urandom());
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_sprite_depth();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic send_item(logic [KIND_W-1:0] kind, int px, int py,
                           logic [VALUE_W-1:0] val);
    int gap;
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.pos_x <= POS_X_W'(px);
    in_if.pos_y <= POS_Y_W'(py);
    in_if.value <= val;
    do @(posedge clk_i); while (!in_if.ready);
    pending_pixels.push_back(predict_pixel(kind, POS_X_W'(px), POS_Y_W'(py), val));
    items_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // draw one pixel; first fill in any store entry the draw would read
  // before it was ever written
  task automatic draw_at(int px, int py);
    int daddr;
    int tx;
    int ty;
    if (covers(px, py)) begin
      daddr = py*SCREEN_W + px;
      if (!depth_ok[daddr]) send_item(KIND_DEPTH, px, py, pick_depth());
      if (spr_depth < depth_mem[daddr]) begin
        tx = tex_coord(px - spr_left, spr_step_x, TEX_W);
        ty = tex_coord(py - spr_top, spr_step_y, TEX_H);
        if (!texel_ok[ty*TEX_W + tx]) send_item(KIND_TEXEL, tx, ty, pick_texel());
      end
    end
    send_item(KIND_DRAW, px, py, $urandom());
  endtask

  // wait until every item has its result, then write all sprite registers;
  // unused upper bits of each word but the depth carry junk the block must drop
  task automatic program_sprite(int left, int top, int width, int height,
                                logic [STEP_W-1:0] step_x, logic [STEP_W-1:0] step_y,
                                logic [DEPTH_W-1:0] depth);
    logic [CFG_DATA_W-1:0] words [CFG_SPRITE_DEPTH+1];
    logic [CFG_DATA_W-1:0] junk;
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    junk = $urandom();
    words[CFG_SPRITE_LEFT]   = {junk[CFG_DATA_W-1:COORD_W], left[COORD_W-1:0]};
    words[CFG_SPRITE_TOP]    = {junk[CFG_DATA_W-1:COORD_W], top[COORD_W-1:0]};
    words[CFG_SPRITE_WIDTH]  = {junk[CFG_DATA_W-1:COORD_W], width[COORD_W-1:0]};
    words[CFG_SPRITE_HEIGHT] = {junk[CFG_DATA_W-1:COORD_W], height[COORD_W-1:0]};
    words[CFG_STEP_X]        = {junk[CFG_DATA_W-1:STEP_W], step_x};
    words[CFG_STEP_Y]        = {~junk[CFG_DATA_W-1:STEP_W], step_y};
    words[CFG_SPRITE_DEPTH]  = depth;
    for (int i = 0; i <= int'(CFG_SPRITE_DEPTH); i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.addr  <= cfg_reg_e'(i);
      cfg_if.wdata <= words[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      apply_reg(cfg_reg_e'(i), words[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // texel and depth loads at the corners, loads outside the texture, the
  // unused kind, and a draw with the reset sprite (zero size)
  task automatic test_loads_and_unused();
    send_item(KIND_TEXEL, 0, 0, '0);
    send_item(KIND_TEXEL, TEX_W - 1, TEX_H - 1, '1);
    send_item(KIND_TEXEL, TEX_W, 0, '1);
    send_item(KIND_TEXEL, 0, TEX_H, '1);
    send_item(KIND_TEXEL, SCREEN_W - 1, SCREEN_H - 1, '1);
    send_item(KIND_DEPTH, 0, 0, '0);
    send_item(KIND_DEPTH, SCREEN_W - 1, SCREEN_H - 1, '1);
    send_item(KIND_UNUSED, SCREEN_W - 1, SCREEN_H - 1, '1);
    send_item(KIND_UNUSED, 0, 0, '0);
    send_item(KIND_DRAW, SCREEN_W - 1, SCREEN_H - 1, '1);
  endtask

  // zero width or zero height covers no pixel at all
  task automatic test_empty_sprite();
    program_sprite(0, 0, 0, 16, STEP_RESET, STEP_RESET, '0);
    send_item(KIND_DRAW, 0, 0, '0);
    send_item(KIND_DRAW, 5, 5, '0);
    program_sprite(0, 0, 16, 0, STEP_RESET, STEP_RESET, '0);
    send_item(KIND_DRAW, 0, 0, '0);
  endtask

  // equal depth, alpha just under and at the key limit, the far edge
  task automatic test_depth_and_alpha();
    program_sprite(0, 0, 4, 4, STEP_RESET, STEP_RESET, 32'd100);
    // equal depth is not nearer
    send_item(KIND_DEPTH, 1, 1, 32'd100);
    draw_at(1, 1);
    // alpha 29 draws, then the same pixel is at equal depth
    send_item(KIND_DEPTH, 2, 1, 32'd101);
    send_item(KIND_TEXEL, 2, 1, {8'(ALPHA_LIMIT - 1), 24'hABCDEF});
    draw_at(2, 1);
    draw_at(2, 1);
    // alpha 30 is keyed out
    send_item(KIND_DEPTH, 3, 1, 32'd101);
    send_item(KIND_TEXEL, 3, 1, {8'(ALPHA_LIMIT), 24'h000000});
    draw_at(3, 1);
    // farthest stored depth, an all-zero texel (alpha 0, under the key limit) draws
    send_item(KIND_DEPTH, 3, 3, '1);
    send_item(KIND_TEXEL, 3, 3, '0);
    draw_at(3, 3);
    // first column past the right edge
    draw_at(4, 0);
  endtask

  // edges at the extremes of their range and texel coordinates that clamp
  task automatic test_clip_and_clamp();
    program_sprite(-2048, -2048, 4095, 4095, '1, '0, '0);
    draw_at(0, 0);
    draw_at(SCREEN_W - 1, SCREEN_H - 1);
    // sprite wholly past the screen, sprite never nearer than anything
    program_sprite(2047, 2047, 4095, 4095, '1, '1, '1);
    send_item(KIND_DRAW, SCREEN_W - 1, SCREEN_H - 1, '0);
    // 8x and 16x steps run past the last texel column and row
    program_sprite(500, 250, 12, 6, 16'h0800, 16'h1000, '0);
    draw_at(SCREEN_W - 1, SCREEN_H - 1);
    draw_at(505, 252);
  endtask

  // random sprites; most items are draws inside the visible part of the
  // sprite, with loads and presets mixed in and some noise
  task automatic test_random_pixels();
    int x_lo;
    int x_hi;
    int y_lo;
    int y_hi;
    int r;
    int phase_end;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      program_sprite(pick_edge(SCREEN_W), pick_edge(SCREEN_H), pick_size(), pick_size(),
                     pick_step(), pick_step(), pick_sprite_depth());
      // sprite rectangle clipped to the screen
      x_lo = (spr_left > 0) ? spr_left : 0;
      y_lo = (spr_top > 0) ? spr_top : 0;
      x_hi = spr_left + spr_width - 1;
      y_hi = spr_top + spr_height - 1;
      if (x_hi > SCREEN_W - 1) x_hi = SCREEN_W - 1;
      if (y_hi > SCREEN_H - 1) y_hi = SCREEN_H - 1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 65 && x_lo <= x_hi && y_lo <= y_hi)
          draw_at($urandom_range(x_hi, x_lo), $urandom_range(y_hi, y_lo));
        else if (r < 75)
          draw_at($urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1));
        else if (r < 83)
          send_item(KIND_TEXEL, $urandom_range(TEX_W - 1), $urandom_range(TEX_H - 1),
                    pick_texel());
        else if (r < 91 && x_lo <= x_hi && y_lo <= y_hi)
          send_item(KIND_DEPTH, $urandom_range(x_hi, x_lo), $urandom_range(y_hi, y_lo),
                    pick_depth());
        else if (r < 91)
          send_item(KIND_DEPTH, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
                    pick_depth());
        else if (r < 96 && r[0])
          send_item(KIND_TEXEL, $urandom_range(SCREEN_W - 1, TEX_W),
                    $urandom_range(SCREEN_H - 1), $urandom());
        else if (r < 96)
          send_item(KIND_TEXEL, $urandom_range(SCREEN_W - 1),
                    $urandom_range(SCREEN_H - 1, TEX_H), $urandom());
        else
          send_item(KIND_UNUSED, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
                    $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and sequencing
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_TEXEL;
    in_if.pos_x  <= '0;
    in_if.pos_y  <= '0;
    in_if.value  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.addr  <= CFG_SPRITE_LEFT;
    cfg_if.wdata <= '0;
    // reset values of the sprite registers
    spr_left       = 0;
    spr_top        = 0;
    spr_width      = 0;
    spr_height     = 0;
    spr_step_x     = STEP_RESET;
    spr_step_y     = STEP_RESET;
    spr_depth      = '0;
    mismatches     = 0;
    items_sent     = 0;
    send_steady    = 1'b0;
    send_mode_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_loads_and_unused();
    test_empty_sprite();
    test_depth_and_alpha();
    test_clip_and_clamp();
    test_random_pixels();

    // drain: every result in, then a few quiet cycles to catch extras
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[scaled_sprite_pixel_depth_test] OK");
    end else begin
      $display("[scaled_sprite_pixel_depth_test] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver pacing: steady stretches and stretches of random stalls
  // ---------------------------------------------------------------------------

  initial begin : sink_pacing
    int  mode_left;
    int  level_left;
    bit  steady;
    mode_left  = 0;
    level_left = 0;
    steady     = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        steady    = ($urandom_range(3) == 0);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (steady) begin
        out_if.ready <= 1'b1;
      end else if (level_left == 0) begin
        if (out_if.ready) begin
          out_if.ready <= 1'b0;
          level_left = stall_len();
        end else begin
          out_if.ready <= 1'b1;
          level_left = $urandom_range(8, 1);
        end
      end else begin
        level_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none actual written %b x %0d y %0d color %h",
                 $time, out_if.written, out_if.out_x, out_if.out_y, out_if.color);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("written", 32'(want.written), 32'(out_if.written));
        compare_field("out_x", 32'(want.x), 32'(out_if.out_x));
        compare_field("out_y", 32'(want.y), 32'(out_if.out_y));
        compare_field("color", want.color, out_if.color);
      end
    end
  end

  // hang detection: any handshake on any channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results pending",
               $time, STUCK_LIMIT, pending_pixels.size());
      $display("[scaled_sprite_pixel_depth_test] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
